[src/grcs_pkg.sv]
// Shared types, constants and the quarter-wave sine function for the grid ray cast scanner.
// It depends on nothing. Every module of the block imports it.
package grcs_pkg;

  localparam int GRID_SIDE   = 256;
  localparam int RAY_COUNT   = 60;
  localparam int ANGLE_UNITS = 3840;
  localparam int QUARTER     = ANGLE_UNITS / 4;
  localparam int RAY_STEP    = ANGLE_UNITS / RAY_COUNT;
  localparam int GRID_AW     = $clog2(GRID_SIDE);
  localparam int ANG_W       = $clog2(ANGLE_UNITS);
  localparam int TAB_W       = $clog2(QUARTER + 1);
  localparam int RAY_W       = 6;
  localparam int RANGE_W     = 9;
  localparam int SIZE_W      = 9;
  localparam int CLEAR_ROWS  = GRID_SIDE;

  typedef enum logic [0:0] {
    CFG_MAP_WIDTH  = 1'b0,
    CFG_MAP_HEIGHT = 1'b1
  } cfg_index_t;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_SCAN  = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RAY,
    ST_PROBE,
    ST_READ,
    ST_CHECK
  } state_t;

  // Taylor series sine of entry k, exactly as the table is defined.
  function automatic logic [15:0] series_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [127:0] p;
    x = (64'(k) * 64'd6746518852) / 64'(ANGLE_UNITS);
    p = 128'(x) * 128'(x);
    x2 = p[93:30];
    term = x;
    sum = x;
    for (int n = 1; n <= 7; n++) begin
      p = 128'(term) * 128'(x2);
      term = p[93:30] / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) != 0) sum = (sum >= term) ? sum - term : 64'd0;
      else sum = sum + term;
    end
    v = (sum + 64'd16384) >> 15;
    if (v > 64'd32768) v = 64'd32768;
    return v[15:0];
  endfunction

endpackage

[src/grid_ray_cast_scanner_core.sv]
// Top level of the grid ray cast scanner: occupancy grid memory, sine table and ray sequencer.
// Depends on grcs_pkg for constants, the state type and the series that fills the table.
//
// Usage: an input beat is taken when start is high and busy is low. A write beat
// (command 0) stores one occupancy bit through a bit write enable on one grid row and
// leaves busy low, so write beats can follow one per cycle. A scan beat (command 1)
// casts RAY_COUNT rays from the pose and emits one result beat per ray, marked by
// out_valid for one cycle; the receiver cannot stall, so every beat leaves at once.
// A ray spends its RAY state on its angle (the sine table read), then for each radius
// step a PROBE state for the probe address and three reads of the registered grid
// memory, each followed by a check, for the center row and the rows above and below.
// A probe that leaves the map or runs out of radius ends the ray in its PROBE state; a
// hit ends it at its check. The result of a ray is on the ports in the cycle after the
// ray ends. The sequential row reads set the rate. Busy falls at the edge that ends
// the last ray, and the next beat can be taken at the following edge.
// After reset the block clears the grid, one row per cycle, all GRID_SIDE (256) rows,
// holding busy high; configuration writes are taken at any time, but map_width and
// map_height (reset 256) should be written only while the block is idle.
module grid_ray_cast_scanner_core
  import grcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_command,
  input  logic [7:0]          in_cell_col,
  input  logic [7:0]          in_cell_row,
  input  logic                in_cell_occupied,
  input  logic [15:0]         in_pose_x,
  input  logic [15:0]         in_pose_y,
  input  logic [11:0]         in_heading,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [SIZE_W-1:0]   cfg_data,
  output logic                out_valid,
  output logic [RANGE_W-1:0]  out_ray_range,
  output logic [RAY_W-1:0]    out_ray_index,
  output logic                out_ray_hit,
  output logic                out_last_ray
);

  // The grid is one bit per cell, stored as rows; each row is a memory word.
  logic [GRID_SIDE-1:0] grid_mem [GRID_SIDE];
  logic [GRID_SIDE-1:0] row_q;
  logic [GRID_AW-1:0]   rd_addr;
  logic                 wr_en;
  logic [GRID_AW-1:0]   wr_addr;
  logic [GRID_SIDE-1:0] wr_mask, wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int b = 0; b < GRID_SIDE; b++) begin
        if (wr_mask[b]) grid_mem[wr_addr][b] <= wr_data[b];
      end
    end
    row_q <= grid_mem[rd_addr];
  end

  // Quarter-wave sine table in Q1.15, read at the sine and cosine address each cycle.
  logic [15:0] sine_rom [QUARTER + 1];
  logic [15:0] sin_q, cos_q;
  logic [TAB_W-1:0] sin_addr, cos_addr;
  logic sin_neg, cos_neg;

  initial begin
    for (int k = 0; k <= QUARTER; k++) sine_rom[k] = series_sine(k);
  end

  always_ff @(posedge clk) begin
    sin_q <= sine_rom[sin_addr];
    cos_q <= sine_rom[cos_addr];
  end

  state_t state_r, state_nxt;
  logic [SIZE_W-1:0] map_w_r, map_h_r;
  logic [GRID_AW-1:0] clr_r;
  logic [15:0] px_r, py_r;
  logic [ANG_W-1:0] head_r;
  logic [RAY_W-1:0] ray_r;
  logic [RANGE_W-1:0] rad_r;
  logic signed [17:0] cos_r, sin_r;
  logic signed [28:0] prod_c_r, prod_r_r;
  logic signed [RANGE_W+1:0] col_r, row_r;
  logic [1:0] sub_r;      // which of three rows is being read
  logic [2:0] nb_hit_r;   // accumulated hits over the three rows
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [RANGE_W:0] maxr;

  assign w_eff = (map_w_r > SIZE_W'(GRID_SIDE)) ? SIZE_W'(GRID_SIDE) : map_w_r;
  assign h_eff = (map_h_r > SIZE_W'(GRID_SIDE)) ? SIZE_W'(GRID_SIDE) : map_h_r;
  assign maxr  = (RANGE_W+1)'(w_eff) + (RANGE_W+1)'(h_eff);

  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  logic accept;
  assign accept = start && !busy;

  // Angle of the current ray and its trig values.
  logic [ANG_W:0] ang_sum;
  logic [ANG_W-1:0] ang, ang_c;
  always_comb begin
    ang_sum = (ANG_W+1)'(head_r) + (ANG_W+1)'(ray_r) * (ANG_W+1)'(RAY_STEP);
    ang = (ang_sum >= (ANG_W+1)'(ANGLE_UNITS)) ? ANG_W'(ang_sum - (ANG_W+1)'(ANGLE_UNITS))
                                               : ANG_W'(ang_sum);
    ang_sum = (ANG_W+1)'(ang) + (ANG_W+1)'(QUARTER);
    ang_c = (ang_sum >= (ANG_W+1)'(ANGLE_UNITS)) ? ANG_W'(ang_sum - (ANG_W+1)'(ANGLE_UNITS))
                                                 : ANG_W'(ang_sum);
  end

  // Folds an angle below ANGLE_UNITS into a table index and a sign bit.
  function automatic logic [TAB_W:0] fold_angle(input logic [ANG_W-1:0] a);
    logic [1:0] q;
    logic [ANG_W-1:0] r;
    logic [TAB_W-1:0] idx;
    if (a >= ANG_W'(3 * QUARTER)) begin
      q = 2'd3;
      r = a - ANG_W'(3 * QUARTER);
    end else if (a >= ANG_W'(2 * QUARTER)) begin
      q = 2'd2;
      r = a - ANG_W'(2 * QUARTER);
    end else if (a >= ANG_W'(QUARTER)) begin
      q = 2'd1;
      r = a - ANG_W'(QUARTER);
    end else begin
      q = 2'd0;
      r = a;
    end
    idx = q[0] ? TAB_W'(ANG_W'(QUARTER) - r) : TAB_W'(r);
    return {q[1], idx};
  endfunction

  // The angle is steady for the whole ray, so the table data is valid from PROBE on.
  assign {sin_neg, sin_addr} = fold_angle(ang);
  assign {cos_neg, cos_addr} = fold_angle(ang_c);

  // Rounding of the probe position, halves away from zero.
  function automatic logic signed [RANGE_W+1:0] round_pos(input logic [15:0] p,
                                                          input logic signed [28:0] m);
    logic signed [40:0] v;
    logic [40:0] a;
    v = ($signed({25'd0, p}) <<< 15) + ($signed({{12{m[28]}}, m}) <<< 8);
    if (!v[40]) begin
      a = (v + 41'sd4194304) >>> 23;
      return (RANGE_W+2)'(a);
    end
    a = ((-v) + 41'sd4194304) >>> 23;
    return (RANGE_W+2)'(-$signed(a));
  endfunction

  logic signed [RANGE_W+1:0] col_n, row_n;
  assign col_n = round_pos(px_r, prod_c_r);
  assign row_n = round_pos(py_r, prod_r_r);

  logic in_map;
  assign in_map = !col_n[RANGE_W+1] && !row_n[RANGE_W+1] &&
                  (col_n < $signed({2'b00, w_eff})) && (row_n < $signed({2'b00, h_eff}));

  // Row being read: sub 0 center, 1 above, 2 below.
  logic signed [RANGE_W+1:0] rrow;
  logic rrow_ok;
  always_comb begin
    case (sub_r)
      2'd1:    rrow = row_r - (RANGE_W+2)'(1);
      2'd2:    rrow = row_r + (RANGE_W+2)'(1);
      default: rrow = row_r;
    endcase
    rrow_ok = !rrow[RANGE_W+1] && (rrow < $signed({2'b00, h_eff}));
  end

  // Bits of the row just read that count for this neighborhood.
  logic [GRID_AW-1:0] cc;
  logic row_hit;
  always_comb begin
    cc = GRID_AW'(col_r);
    row_hit = row_q[cc];
    if (sub_r == 2'd0) begin
      if (col_r > 0 && row_q[cc - 1'b1]) row_hit = 1'b1;
      if (col_r + 1 < $signed({2'b00, w_eff}) && row_q[GRID_AW'(col_r + 1)]) row_hit = 1'b1;
    end
    if (!rrow_ok) row_hit = 1'b0;
  end

  logic hit_now;
  assign hit_now = row_hit || (nb_hit_r != 3'd0);

  // Ray completion conditions evaluated in PROBE (leave map / out of radius).
  logic probe_end;
  assign probe_end = ({1'b0, rad_r} >= maxr) || !in_map;

  logic ray_last;
  assign ray_last = (ray_r == RAY_W'(RAY_COUNT - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == GRID_AW'(CLEAR_ROWS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept && in_command == CMD_SCAN) state_nxt = ST_RAY;
      ST_RAY:   state_nxt = ST_PROBE;
      ST_PROBE: begin
        if (probe_end) state_nxt = ray_last ? ST_IDLE : ST_RAY;
        else state_nxt = ST_READ;
      end
      ST_READ:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (hit_now) state_nxt = ray_last ? ST_IDLE : ST_RAY;
        else if (sub_r != 2'd2) state_nxt = ST_READ;
        else state_nxt = ST_PROBE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = in_cell_row;
    wr_mask = '0;
    wr_data = '0;
    rd_addr = GRID_AW'(rrow);
    if (state_r == ST_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = clr_r;
      wr_mask = '1;
    end else if (accept && in_command == CMD_WRITE) begin
      wr_en = 1'b1;
      wr_mask[in_cell_col] = 1'b1;
      wr_data[in_cell_col] = in_cell_occupied;
    end
  end

  logic [RANGE_W-1:0] out_range_nxt;
  logic out_fire, out_hit_nxt;
  always_comb begin
    out_fire = 1'b0;
    out_hit_nxt = 1'b0;
    out_range_nxt = '0;
    if (state_r == ST_PROBE && probe_end) out_fire = 1'b1;
    if (state_r == ST_CHECK && hit_now) begin
      out_fire = 1'b1;
      out_hit_nxt = 1'b1;
      out_range_nxt = rad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      map_w_r <= SIZE_W'(256);
      map_h_r <= SIZE_W'(256);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAP_WIDTH) map_w_r <= cfg_data;
        else map_h_r <= cfg_data;
      end
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      out_valid <= out_fire;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        px_r <= in_pose_x;
        py_r <= in_pose_y;
        head_r <= (in_heading >= 12'(ANGLE_UNITS)) ? ANG_W'(in_heading - 12'(ANGLE_UNITS))
                                                  : ANG_W'(in_heading);
        ray_r <= '0;
      end
      ST_RAY: begin
        rad_r <= '0;
        prod_c_r <= '0;
        prod_r_r <= '0;
      end
      ST_PROBE: begin
        cos_r <= cos_neg ? -$signed({2'b00, cos_q}) : $signed({2'b00, cos_q});
        sin_r <= sin_neg ? -$signed({2'b00, sin_q}) : $signed({2'b00, sin_q});
        col_r <= col_n;
        row_r <= row_n;
        sub_r <= 2'd0;
        nb_hit_r <= '0;
      end
      ST_CHECK: begin
        nb_hit_r <= nb_hit_r | {2'b00, row_hit};
        sub_r <= sub_r + 2'd1;
        if (!hit_now && sub_r == 2'd2) begin
          rad_r <= rad_r + 1'b1;
          prod_c_r <= prod_c_r + 29'(cos_r);
          prod_r_r <= prod_r_r + 29'(sin_r);
        end
      end
      default: ;
    endcase
    // A ray ends exactly when its result fires; IDLE never fires.
    if (out_fire) ray_r <= ray_r + 1'b1;
    out_ray_range <= out_range_nxt;
    out_ray_hit <= out_hit_nxt;
    out_ray_index <= ray_r;
    out_last_ray <= ray_last;
  end

endmodule

[src/grcs_checker.sv]
// Port-level checker for the grid ray cast scanner, bound to the top level.
// Depends on grcs_pkg for the ray count.
module grcs_checker
  import grcs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [RAY_W-1:0] out_ray_index,
  input logic [8:0]       out_ray_range,
  input logic             out_ray_hit,
  input logic             out_last_ray
);
  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ray_hit |-> out_ray_range == 9'd0) else $error("range without hit");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last_ray == (out_ray_index == RAY_W'(RAY_COUNT - 1)))
    else $error("last flag wrong");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_ray |-> $past(busy)) else $error("result while idle");
endmodule

bind grid_ray_cast_scanner_core grcs_checker u_grcs_checker (.*);

[test/grid_ray_cast_scanner_core_check.sv]
// Checker for the grid ray cast scanner: watches the command, configuration and ray beats.
// It keeps its own occupancy grid and sine table, predicts every ray and compares.
// Depends on grcs_pkg for sizes and the command and register codes.
module grid_ray_cast_scanner_core_check
  import grcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_command,
  input  logic [7:0]         in_cell_col,
  input  logic [7:0]         in_cell_row,
  input  logic               in_cell_occupied,
  input  logic [15:0]        in_pose_x,
  input  logic [15:0]        in_pose_y,
  input  logic [11:0]        in_heading,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [SIZE_W-1:0]  cfg_data,
  input  logic               out_valid,
  input  logic [RANGE_W-1:0] out_ray_range,
  input  logic [RAY_W-1:0]   out_ray_index,
  input  logic               out_ray_hit,
  input  logic               out_last_ray,
  output int                 failures,
  output int                 outstanding
);

  typedef struct packed {
    logic [RANGE_W-1:0] range;
    logic [RAY_W-1:0]   index;
    logic               hit;
    logic               last;
  } ray_beat_t;

  ray_beat_t   ray_queue[$];
  bit          grid_bits[GRID_SIDE * GRID_SIDE];
  logic [15:0] sine_q15[QUARTER + 1];
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;

  function automatic logic [15:0] taylor_sine(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x = (64'(k) * 64'd6746518852) / 64'(ANGLE_UNITS);
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = (sum >= term) ? sum - term : 64'd0;
      else sum = sum + term;
    end
    v = (sum + 64'd16384) >> 15;
    if (v > 64'd32768) v = 64'd32768;
    return v[15:0];
  endfunction

  function automatic longint folded_sine(int unsigned a);
    int unsigned q;
    int unsigned rem;
    longint v;
    a = a % ANGLE_UNITS;
    q = a / QUARTER;
    rem = a % QUARTER;
    v = (q % 2 == 1) ? longint'(sine_q15[QUARTER - rem]) : longint'(sine_q15[rem]);
    return (q >= 2) ? -v : v;
  endfunction

  // Round a Q23 value to the nearest integer, halves away from zero.
  function automatic longint round_q23(longint v);
    if (v >= 0) return (v + (64'sd1 <<< 22)) >>> 23;
    return -(((-v) + (64'sd1 <<< 22)) >>> 23);
  endfunction

  function automatic bit occupied_at(longint col, longint row, longint w, longint h);
    if (col < 0 || col >= w || row < 0 || row >= h) return 1'b0;
    return grid_bits[row * GRID_SIDE + col];
  endfunction

  task automatic predict_scan(logic [15:0] pose_x, logic [15:0] pose_y, logic [11:0] hd);
    longint w;
    longint h;
    longint px;
    longint py;
    longint c;
    longint s;
    longint col;
    longint row;
    int unsigned ang;
    ray_beat_t beat;
    w = (width_reg > GRID_SIDE) ? GRID_SIDE : width_reg;
    h = (height_reg > GRID_SIDE) ? GRID_SIDE : height_reg;
    px = longint'(pose_x) * 32768;
    py = longint'(pose_y) * 32768;
    for (int i = 0; i < RAY_COUNT; i++) begin
      ang = (hd % ANGLE_UNITS) + (i * ANGLE_UNITS) / RAY_COUNT;
      c = folded_sine(ang + QUARTER);
      s = folded_sine(ang);
      beat = '0;
      beat.index = RAY_W'(i);
      beat.last = (i == RAY_COUNT - 1);
      for (longint r = 0; r < w + h; r++) begin
        col = round_q23(px + r * c * 256);
        row = round_q23(py + r * s * 256);
        if (col < 0 || col >= w || row < 0 || row >= h) break;
        if (occupied_at(col, row, w, h) || occupied_at(col - 1, row, w, h) ||
            occupied_at(col + 1, row, w, h) || occupied_at(col, row - 1, w, h) ||
            occupied_at(col, row + 1, w, h)) begin
          beat.range = RANGE_W'(r);
          beat.hit = 1'b1;
          break;
        end
      end
      ray_queue.push_back(beat);
    end
  endtask

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    failures++;
  endtask

  initial begin
    for (int k = 0; k <= QUARTER; k++) sine_q15[k] = taylor_sine(k);
  end

  always @(posedge clk) begin
    ray_beat_t want;
    if (!rst_n) begin
      for (int k = 0; k < GRID_SIDE * GRID_SIDE; k++) grid_bits[k] = 1'b0;
      width_reg = SIZE_W'(256);
      height_reg = SIZE_W'(256);
      ray_queue.delete();
      failures = 0;
    end else begin
      if (out_valid) begin
        if (ray_queue.size() == 0) begin
          report($sformatf("ray beat index %0d with nothing expected", out_ray_index));
        end else begin
          want = ray_queue.pop_front();
          if (out_ray_range !== want.range || out_ray_index !== want.index ||
              out_ray_hit !== want.hit || out_last_ray !== want.last)
            report($sformatf("ray got r=%0d i=%0d h=%0d l=%0d want r=%0d i=%0d h=%0d l=%0d",
                             out_ray_range, out_ray_index, out_ray_hit, out_last_ray,
                             want.range, want.index, want.hit, want.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAP_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (start && !busy) begin
        if (in_command == CMD_WRITE) grid_bits[in_cell_row * GRID_SIDE + in_cell_col] =
            in_cell_occupied;
        else predict_scan(in_pose_x, in_pose_y, in_heading);
      end
    end
    outstanding = ray_queue.size();
  end

endmodule

[test/grid_ray_cast_scanner_core_test.sv]
// Testbench top for the grid ray cast scanner: clock, reset, command and register stimulus.
// Depends on grcs_pkg, the block and grid_ray_cast_scanner_core_check.
module grid_ray_cast_scanner_core_test;
  import grcs_pkg::*;

  // The bound allows four times what some 115 beats would need if every one of them
  // were a worst-case scan.
  localparam int CYCLE_LIMIT = 100000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = 1'b0;
  logic [7:0] in_cell_col = '0;
  logic [7:0] in_cell_row = '0;
  logic in_cell_occupied = 1'b0;
  logic [15:0] in_pose_x = '0;
  logic [15:0] in_pose_y = '0;
  logic [11:0] in_heading = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic out_valid;
  logic [RANGE_W-1:0] out_ray_range;
  logic [RAY_W-1:0] out_ray_index;
  logic out_ray_hit;
  logic out_last_ray;
  int failures;
  int outstanding;
  int cycles = 0;
  int map_w;
  int map_h;

  grid_ray_cast_scanner_core dut (.*);
  grid_ray_cast_scanner_core_check checker_inst (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost ray beat ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one command beat and hold it until the block takes it. Start is
  // left high so a back-to-back beat needs no second assignment in the step.
  task automatic send_beat(logic cmd, logic [7:0] col, logic [7:0] row, logic occ,
                           logic [15:0] px, logic [15:0] py, logic [11:0] hd);
    in_command <= cmd;
    in_cell_col <= col;
    in_cell_row <= row;
    in_cell_occupied <= occ;
    in_pose_x <= px;
    in_pose_y <= py;
    in_heading <= hd;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random gap after a beat: mostly none or short, now and then long.
  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Registers change only with the block idle and every ray beat already seen.
  task automatic write_reg(cfg_index_t idx, int value);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= SIZE_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_map(int w, int h);
    write_reg(CFG_MAP_WIDTH, w);
    write_reg(CFG_MAP_HEIGHT, h);
    map_w = (w > GRID_SIDE) ? GRID_SIDE : w;
    map_h = (h > GRID_SIDE) ? GRID_SIDE : h;
  endtask

  // One random beat. Writes mostly land inside the map in use so scans find
  // obstacles; poses mostly sit inside the map so rays march before leaving.
  task automatic random_beat();
    logic [7:0] col;
    logic [7:0] row;
    logic [15:0] px;
    logic [15:0] py;
    if ($urandom_range(0, 4) != 0) begin
      col = 8'($urandom);
      row = 8'($urandom);
      if (map_w > 0 && $urandom_range(0, 4) != 0) col = 8'($urandom_range(0, map_w - 1));
      if (map_h > 0 && $urandom_range(0, 4) != 0) row = 8'($urandom_range(0, map_h - 1));
      send_beat(CMD_WRITE, col, row, $urandom_range(0, 3) != 0, 16'($urandom),
                16'($urandom), 12'($urandom));
    end else begin
      px = 16'($urandom);
      py = 16'($urandom);
      if (map_w > 0 && $urandom_range(0, 3) != 0) px = 16'($urandom_range(0, map_w * 256 - 1));
      if (map_h > 0 && $urandom_range(0, 3) != 0) py = 16'($urandom_range(0, map_h * 256 - 1));
      send_beat(CMD_SCAN, 8'($urandom), 8'($urandom), 1'($urandom), px, py,
                12'($urandom_range(0, 4095)));
    end
    idle_gap();
  endtask

  initial begin
    map_w = GRID_SIDE;
    map_h = GRID_SIDE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset map size. An empty grid means every ray
    // leaves the map; then corner obstacles and an overwritten cell.
    send_beat(CMD_SCAN, 8'h00, 8'h00, 1'b0, 16'h8000, 16'h8000, 12'd0);
    idle_gap();
    send_beat(CMD_WRITE, 8'd0, 8'd0, 1'b1, 16'h0000, 16'h0000, 12'd0);
    send_beat(CMD_WRITE, 8'd255, 8'd255, 1'b1, 16'hFFFF, 16'hFFFF, 12'hFFF);
    send_beat(CMD_WRITE, 8'd255, 8'd0, 1'b1, 16'h0000, 16'hFFFF, 12'd0);
    send_beat(CMD_WRITE, 8'd0, 8'd255, 1'b0, 16'hFFFF, 16'h0000, 12'd0);
    send_beat(CMD_WRITE, 8'd0, 8'd255, 1'b1, 16'h0000, 16'h0000, 12'd0);
    send_beat(CMD_WRITE, 8'd255, 8'd0, 1'b0, 16'h0000, 16'h0000, 12'd0);
    idle_gap();
    // A heading past the last unit wraps around; a pose at the top of its
    // range rounds outside the map so every ray ends at once.
    send_beat(CMD_SCAN, 8'hFF, 8'hFF, 1'b1, 16'h0000, 16'h0000, 12'd3839);
    send_beat(CMD_SCAN, 8'h00, 8'h00, 1'b0, 16'hFFFF, 16'hFFFF, 12'hFFF);
    send_beat(CMD_SCAN, 8'h00, 8'h00, 1'b0, 16'h0080, 16'hFF7F, 12'd3840);
    idle_gap();

    // Size zero ends every ray at once; oversize values act as the full side.
    set_map(0, 256);
    send_beat(CMD_SCAN, 8'h00, 8'h00, 1'b0, 16'h0100, 16'h0100, 12'd100);
    set_map(511, 0);
    send_beat(CMD_SCAN, 8'h00, 8'h00, 1'b0, 16'h0100, 16'h0100, 12'd960);
    set_map(1, 1);
    send_beat(CMD_SCAN, 8'h00, 8'h00, 1'b0, 16'h0000, 16'h0000, 12'd0);
    send_beat(CMD_WRITE, 8'd0, 8'd0, 1'b0, 16'h0000, 16'h0000, 12'd0);
    send_beat(CMD_SCAN, 8'h00, 8'h00, 1'b0, 16'h007F, 16'h007F, 12'd1920);
    idle_gap();

    // Random part over several map sizes, the extremes among them.
    set_map(16, 16);
    repeat (25) random_beat();
    set_map(1, 1);
    repeat (10) random_beat();
    set_map(40, 8);
    repeat (25) random_beat();
    set_map(511, 3);
    repeat (15) random_beat();
    set_map(9, 0);
    repeat (5) random_beat();
    set_map(24, 31);
    repeat (20) random_beat();
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
